// ===== hdl/sa_pkg.sv =====
package sa_pkg;

	localparam int SLOTS  = 32;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W   = 16;
	localparam int TAG_W  = 32;
	localparam int IDX_W  = 8;

	localparam logic [ID_W-1:0] BASE_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_GRANT   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_LOOKUP  = 2'd2
	} op_t;

	localparam logic [1:0] STATUS_IDLE = 2'd0;

	// write request into the tag store
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] addr;
		logic [TAG_W-1:0]  data;
	} tag_wr_t;

	// answer of the free-slot search
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] idx;
	} free_slot_t;

endpackage

// ===== hdl/sa_find_free.sv =====
module sa_find_free
	import sa_pkg::*;
(
	input  logic [SLOTS-1:0] used,
	output free_slot_t       free_slot
);

	// lowest clear bit wins: scan from the top so the lowest index is written last
	always_comb begin
		free_slot.found = 1'b0;
		free_slot.idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				free_slot.found = 1'b1;
				free_slot.idx   = SLOT_W'(i);
			end
		end
	end

endmodule

// ===== hdl/sa_owner_store.sv =====
module sa_owner_store
	import sa_pkg::*;
(
	input  logic              clk,
	input  tag_wr_t           wr,
	input  logic [SLOT_W-1:0] rd_addr,
	output logic [TAG_W-1:0]  rd_data
);

	logic [TAG_W-1:0] owner_q [SLOTS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			owner_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = owner_q[rd_addr];

endmodule

// ===== hdl/slot_allocator_with_id_map_unit.sv =====
// Flow: a request beat accepted into the input register moves on into the result register
//   once that register is empty or drains, and its result is offered from the result register.
// Throughput: one request per cycle unless a held result stalls it; the free-slot priority encoder and the tag
//   register file settle between the two registers, so back-to-back requests see fresh state.
// Reset (arst_n low, asynchronous): all slots free, base_local_id = 65535, both
//   registers empty. Stored tags are not cleared; a tag is only read from an occupied slot.
module slot_allocator_with_id_map_unit
	import sa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [ID_W-1:0]   cfg_data,

	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [TAG_W-1:0]  owner_tag,
	input  logic [1:0]        owner_status,
	input  logic [ID_W-1:0]   local_id,

	output logic              out_valid,
	input  logic              out_ready,
	output logic              ok,
	output logic [ID_W-1:0]   granted_local_id,
	output logic [IDX_W-1:0]  slot_index,
	output logic [TAG_W-1:0]  found_tag
);

	// configuration: always ready; to be written only while the block is idle, which the block itself does not enforce
	logic [ID_W-1:0] base_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	// input register
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [1:0]        status_s1;
	logic [ID_W-1:0]   id_s1;

	logic              out_valid_q;
	logic              advance;

	// the request moves on whenever the result register is empty or drains this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= op;
			tag_s1    <= owner_tag;
			status_s1 <= owner_status;
			id_s1     <= local_id;
		end
	end

	// occupancy bits and tag store
	logic [SLOTS-1:0] used_q;
	free_slot_t       free_slot;
	tag_wr_t          tag_wr;
	logic [TAG_W-1:0] stored_tag;

	sa_find_free u_find_free (
		.used      (used_q),
		.free_slot (free_slot)
	);

	// grant decision: idle owner, a free slot, and an id that stays non-negative
	logic            is_grant;
	logic            is_release;
	logic            is_lookup;
	logic            grant_ok;
	logic [ID_W-1:0] grant_id;

	assign is_grant   = (op_s1 == OP_GRANT);
	assign is_release = (op_s1 == OP_RELEASE);
	assign is_lookup  = (op_s1 == OP_LOOKUP);

	assign grant_ok = is_grant && (status_s1 == STATUS_IDLE) && free_slot.found &&
		(ID_W'(free_slot.idx) <= base_q);
	assign grant_id = base_q - ID_W'(free_slot.idx);

	// map the local id back to a slot: the id must lie inside the window below base
	logic [ID_W-1:0]   id_diff;
	logic              in_window;
	logic [SLOT_W-1:0] lk_idx;
	logic              lk_ok;

	assign id_diff   = base_q - id_s1;
	assign in_window = (id_s1 <= base_q) && ({1'b0, id_diff} < (ID_W + 1)'(SLOTS));
	assign lk_idx    = id_diff[SLOT_W-1:0];
	assign lk_ok     = (is_release || is_lookup) && in_window && used_q[lk_idx];

	assign tag_wr.we   = advance && grant_ok;
	assign tag_wr.addr = free_slot.idx;
	assign tag_wr.data = tag_s1;

	sa_owner_store u_owner_store (
		.clk     (clk),
		.wr      (tag_wr),
		.rd_addr (lk_idx),
		.rd_data (stored_tag)
	);

	// set on grant, clear on release, only when the beat advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (advance) begin
			if (grant_ok) begin
				used_q[free_slot.idx] <= 1'b1;
			end else if (lk_ok && is_release) begin
				used_q[lk_idx] <= 1'b0;
			end
		end
	end

	// result register: every field is zero on a failed request
	logic              ok_q;
	logic [ID_W-1:0]   gid_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TAG_W-1:0]  tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			priority if (grant_ok) begin
				ok_q  <= 1'b1;
				gid_q <= grant_id;
				idx_q <= IDX_W'(free_slot.idx);
				tag_q <= '0;
			end else if (lk_ok) begin
				ok_q  <= 1'b1;
				gid_q <= '0;
				idx_q <= IDX_W'(lk_idx);
				tag_q <= stored_tag;
			end else begin
				ok_q  <= 1'b0;
				gid_q <= '0;
				idx_q <= '0;
				tag_q <= '0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign ok               = ok_q;
	assign granted_local_id = gid_q;
	assign slot_index       = idx_q;
	assign found_tag        = tag_q;

	// a successful grant leaves its slot occupied
	a_grant_sets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && grant_ok |=> used_q[$past(free_slot.idx)])
		else $error("granted slot not marked used");

	// a successful release leaves its slot free
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && lk_ok && is_release |=> !used_q[$past(lk_idx)])
		else $error("released slot still marked used");

	// a failed result carries all-zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> (gid_q == '0) && (idx_q == '0) && (tag_q == '0))
		else $error("failed result with nonzero fields");

	// a full input register behind a stalled result must block new beats
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready && !advance)
		else $error("input accepted while pipeline stalled");

endmodule

// ===== tb/sv/slot_alloc_checker.sv =====
`timescale 1ns / 1ps

module slot_alloc_checker
	import sa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [ID_W-1:0]   cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        op,
	input  logic [TAG_W-1:0]  owner_tag,
	input  logic [1:0]        owner_status,
	input  logic [ID_W-1:0]   local_id,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              ok,
	input  logic [ID_W-1:0]   granted_local_id,
	input  logic [IDX_W-1:0]  slot_index,
	input  logic [TAG_W-1:0]  found_tag,
	output int                errors,
	output int                pending,
	output int                results_seen,
	output int                successes,
	output int                full_refusals
);

	typedef struct packed {
		logic             ok;
		logic [ID_W-1:0]  gid;
		logic [IDX_W-1:0] idx;
		logic [TAG_W-1:0] tag;
	} alloc_result_t;

	logic [SLOTS-1:0] occupied;
	logic [TAG_W-1:0] owner_of [SLOTS];
	logic [ID_W-1:0]  base_id;
	alloc_result_t    due_results[$];

	int err_cnt  = 0;
	int res_cnt  = 0;
	int ok_cnt   = 0;
	int full_cnt = 0;

	assign errors        = err_cnt;
	assign pending       = due_results.size();
	assign results_seen  = res_cnt;
	assign successes     = ok_cnt;
	assign full_refusals = full_cnt;

	// Compute the answer to one request and advance the slot table.
	function automatic alloc_result_t alloc_outcome(logic [1:0] req_op, logic [TAG_W-1:0] tag,
			logic [1:0] status, logic [ID_W-1:0] id);
		alloc_result_t r;
		int free_idx;
		int s;
		r = '0;
		free_idx = SLOTS;
		unique case (req_op)
			OP_GRANT: begin
				if (status == STATUS_IDLE) begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!occupied[SLOT_W'(i)])
							free_idx = i;
					if (free_idx >= SLOTS) begin
						full_cnt++;
					end else if (free_idx <= base_id) begin
						occupied[SLOT_W'(free_idx)] = 1'b1;
						owner_of[SLOT_W'(free_idx)] = tag;
						r.ok  = 1'b1;
						r.gid = ID_W'(int'(base_id) - free_idx);
						r.idx = IDX_W'(free_idx);
					end
				end
			end
			OP_RELEASE, OP_LOOKUP: begin
				if (id <= base_id && (base_id - id) < SLOTS) begin
					s = int'(base_id - id);
					if (occupied[SLOT_W'(s)]) begin
						r.ok  = 1'b1;
						r.idx = IDX_W'(s);
						r.tag = owner_of[SLOT_W'(s)];
						if (req_op == OP_RELEASE)
							occupied[SLOT_W'(s)] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			occupied = '0;
			base_id  = BASE_RESET;
			due_results.delete();
		end else begin
			// Check the outgoing beat first so that a beat entering at this edge is never
			// matched against a result leaving at the same edge.
			if (out_valid && out_ready) begin
				res_cnt++;
				if (due_results.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, got ok=%b id=%h idx=%h tag=%h",
						$time, ok, granted_local_id, slot_index, found_tag);
				end else begin
					want = due_results.pop_front();
					if (want.ok)
						ok_cnt++;
					report_field("ok", 32'(want.ok), 32'(ok));
					report_field("granted_local_id", 32'(want.gid), 32'(granted_local_id));
					report_field("slot_index", 32'(want.idx), 32'(slot_index));
					report_field("found_tag", want.tag, found_tag);
				end
			end
			if (cfg_valid && cfg_ready)
				base_id = cfg_data;
			if (in_valid && in_ready)
				due_results.insert(due_results.size(),
					alloc_outcome(op, owner_tag, owner_status, local_id));
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
	import sa_pkg::*;
;

	// Request codes outside the package enum and owner states other than idle.
	localparam logic [1:0] OP_UNKNOWN    = 2'd3;
	localparam logic [1:0] STATUS_IN_USE = 2'd1;
	localparam logic [1:0] STATUS_LOCKED = 2'd2;

	// Long receiver hold-off used to back the pipeline up into the request port.
	localparam int HOLD_CYCLES = 200;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [ID_W-1:0]   cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        op;
	logic [TAG_W-1:0]  owner_tag;
	logic [1:0]        owner_status;
	logic [ID_W-1:0]   local_id;
	logic              out_valid;
	logic              out_ready;
	logic              ok;
	logic [ID_W-1:0]   granted_local_id;
	logic [IDX_W-1:0]  slot_index;
	logic [TAG_W-1:0]  found_tag;

	int fail_cnt;
	int left_cnt;
	int result_cnt;
	int success_cnt;
	int full_cnt;

	// Idle percentages for the request sender and the result receiver.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int base_writes = 0;
	bit hold_off_req = 1'b0;

	slot_allocator_with_id_map_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.owner_tag        (owner_tag),
		.owner_status     (owner_status),
		.local_id         (local_id),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.ok               (ok),
		.granted_local_id (granted_local_id),
		.slot_index       (slot_index),
		.found_tag        (found_tag)
	);

	slot_alloc_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.owner_tag        (owner_tag),
		.owner_status     (owner_status),
		.local_id         (local_id),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.ok               (ok),
		.granted_local_id (granted_local_id),
		.slot_index       (slot_index),
		.found_tag        (found_tag),
		.errors           (fail_cnt),
		.pending          (left_cnt),
		.results_seen     (result_cnt),
		.successes        (success_cnt),
		.full_refusals    (full_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: stall at random, or hold off for a long fixed stretch when asked.
	// This process is the only driver of out_ready, so it changes once per edge at most.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Send one request beat. Idle first at random, then hold valid and payload until
	// the block takes the beat. Valid stays high on return so back-to-back beats
	// never see a low-high glitch within one step.
	task automatic send_req(logic [1:0] req_op, logic [TAG_W-1:0] tag, logic [1:0] status,
			logic [ID_W-1:0] id);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= req_op;
		owner_tag    <= tag;
		owner_status <= status;
		local_id     <= id;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every outstanding result has left the block.
	// Sample the checker at the falling edge to stay clear of its update.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (left_cnt != 0);
		@(posedge clk);
	endtask

	// Write the base id only while the block is empty.
	task automatic write_base(logic [ID_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_writes++;
	endtask

	// One random phase. Alternate stretches of fill (mostly grants) and drain
	// (mostly releases and lookups) so the table swings between empty and full.
	// Most ids land inside the window or just outside it; a few are fully random.
	task automatic run_phase(logic [ID_W-1:0] base, int tx_pct, int rx_pct, int count,
			bit squeeze);
		int r;
		int offs;
		bit filling;
		logic [1:0] pick_op;
		logic [1:0] pick_st;
		logic [ID_W-1:0] pick_id;
		write_base(base);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (squeeze)
			hold_off_req = 1'b1;
		for (int k = 0; k < count; k++) begin
			filling = ((k / 40) % 2) == 0;
			r = $urandom_range(99);
			if (filling)
				pick_op = (r < 80) ? OP_GRANT : (r < 88) ? OP_RELEASE :
					(r < 96) ? OP_LOOKUP : OP_UNKNOWN;
			else
				pick_op = (r < 20) ? OP_GRANT : (r < 65) ? OP_RELEASE :
					(r < 95) ? OP_LOOKUP : OP_UNKNOWN;
			pick_st = ($urandom_range(99) < 85) ? STATUS_IDLE :
				(($urandom_range(1) == 0) ? STATUS_IN_USE : STATUS_LOCKED);
			if ($urandom_range(7) == 0) begin
				pick_id = ID_W'($urandom);
			end else begin
				offs = $urandom_range(SLOTS);
				pick_id = (offs <= base) ? ID_W'(int'(base) - offs) : base + ID_W'(1);
			end
			send_req(pick_op, $urandom, pick_st, pick_id);
		end
	endtask

	// Hard stop in case the handshakes ever hang.
	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		op           = OP_GRANT;
		owner_tag    = '0;
		owner_status = STATUS_IDLE;
		local_id     = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first at the reset base of 65535.
		tx_idle_pct = 28;
		rx_idle_pct = 69;
		send_req(OP_GRANT, 32'h0000_0000, STATUS_IDLE, 16'h0000);
		send_req(OP_GRANT, 32'hFFFF_FFFF, STATUS_IDLE, 16'hFFFF);
		// Grants from an owner that is not idle are refused.
		send_req(OP_GRANT, 32'h1234_5678, STATUS_IN_USE, 16'h0000);
		send_req(OP_GRANT, 32'h1234_5678, STATUS_LOCKED, 16'h0000);
		send_req(OP_LOOKUP, 32'h0, STATUS_IDLE, 16'hFFFF);
		send_req(OP_LOOKUP, 32'h0, STATUS_IDLE, 16'hFFFE);
		// Empty slot, then an id far below the window.
		send_req(OP_LOOKUP, 32'h0, STATUS_IDLE, 16'hFFFD);
		send_req(OP_LOOKUP, 32'h0, STATUS_IDLE, 16'h0000);
		send_req(OP_RELEASE, 32'h0, STATUS_IDLE, 16'hFFFF);
		send_req(OP_RELEASE, 32'h0, STATUS_IDLE, 16'hFFFF);
		// The freed slot zero is the lowest free one again.
		send_req(OP_GRANT, 32'hA5A5_5A5A, STATUS_IDLE, 16'h0000);
		send_req(OP_UNKNOWN, 32'hFFFF_FFFF, STATUS_LOCKED, 16'hFFFE);
		send_req(OP_RELEASE, 32'h0, STATUS_IDLE, 16'hFFFE);
		send_req(OP_RELEASE, 32'h0, STATUS_IDLE, 16'hFFFF);

		// Base of zero: only slot zero has a valid id, the next grant would go negative.
		write_base(16'd0);
		send_req(OP_GRANT, 32'hC3C3_3C3C, STATUS_IDLE, 16'h0000);
		send_req(OP_GRANT, 32'h0F0F_F0F0, STATUS_IDLE, 16'h0000);
		send_req(OP_LOOKUP, 32'h0, STATUS_IDLE, 16'd1);

		// Move the base while slot zero is held; its id follows the new base.
		write_base(16'd5);
		send_req(OP_LOOKUP, 32'h0, STATUS_IDLE, 16'd5);
		send_req(OP_GRANT, 32'h5555_AAAA, STATUS_IDLE, 16'h0000);
		send_req(OP_RELEASE, 32'h0, STATUS_IDLE, 16'd0);
		send_req(OP_RELEASE, 32'h0, STATUS_IDLE, 16'd5);
		send_req(OP_RELEASE, 32'h0, STATUS_IDLE, 16'd4);

		// Random phases: full window, a narrow window, then the top base with
		// no idling and a long receiver hold-off at the start.
		run_phase(16'd31, 28, 69, 160, 1'b0);
		run_phase(ID_W'($urandom_range(4, 28)), 69, 28, 160, 1'b0);
		run_phase(16'hFFFF, 0, 0, 160, 1'b1);

		wait_drained();
		repeat (4) @(posedge clk);

		$display("covered %0d requests under %0d base settings; %0d succeeded",
			result_cnt, base_writes, success_cnt);
		$display("grants refused on a full table: %0d; receiver hold-off of %0d cycles applied",
			full_cnt, HOLD_CYCLES);
		if (fail_cnt == 0 && left_cnt == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== slot_allocator_with_id_map_unit.f =====
hdl/sa_pkg.sv
hdl/sa_find_free.sv
hdl/sa_owner_store.sv
hdl/slot_allocator_with_id_map_unit.sv
tb/sv/slot_alloc_checker.sv
tb/sv/tb_top.sv
